@@ rtl/dfbs_pkg.sv @@
// Shared types, constants and reset values for the diagnostic frame byte-stuffing codec.
package dfbs_pkg;

    // Register indexes on the configuration port
    localparam logic [7:0] REG_MODE   = 8'd0;
    localparam logic [7:0] REG_FLAG   = 8'd1;
    localparam logic [7:0] REG_ESCAPE = 8'd2;
    localparam logic [7:0] REG_MASK   = 8'd3;

    // Mode codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Reset values of the registers
    localparam logic [7:0] FLAG_RESET   = 8'h7E;
    localparam logic [7:0] ESCAPE_RESET = 8'h7D;
    localparam logic [7:0] MASK_RESET   = 8'h20;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Bit positions of the parts of one command, in emission order
    localparam int PART_OPEN  = 0;
    localparam int PART_ESC   = 1;
    localparam int PART_DATA  = 2;
    localparam int PART_CLOSE = 3;
    localparam int PART_N     = 4;

    typedef struct packed {
        logic       mode;
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] complement_mask;
    } t_cfg;

    // One classified item: which parts to emit, and the data byte
    typedef struct packed {
        logic [PART_N-1:0] parts;
        logic              eof;
        logic [7:0]        data;
    } t_cmd;

endpackage

@@ rtl/dfbs_front.sv @@
// Front part: configuration registers, decode state and classification of input beats.
module dfbs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration write channel
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    // input beat
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_start,
    input  logic           i_end,
    // queue side
    input  logic           i_q_full,
    output logic           o_push,
    output dfbs_pkg::t_cmd o_cmd,
    output dfbs_pkg::t_cfg o_cfg
);

    dfbs_pkg::t_cfg r_cfg;
    logic r_esc_pend, n_esc_pend;
    logic r_in_frame, n_in_frame;
    logic r_has_data, n_has_data;

    logic accept;
    logic cfg_wr;
    logic is_flag;
    logic is_esc;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_ready     = !i_q_full;
    assign accept      = i_valid && !i_q_full;
    assign is_flag     = (i_byte == r_cfg.flag_byte);
    assign is_esc      = (i_byte == r_cfg.escape_byte);
    assign o_cfg       = r_cfg;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= dfbs_pkg::MODE_ENCODE;
            r_cfg.flag_byte       <= dfbs_pkg::FLAG_RESET;
            r_cfg.escape_byte     <= dfbs_pkg::ESCAPE_RESET;
            r_cfg.complement_mask <= dfbs_pkg::MASK_RESET;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                dfbs_pkg::REG_MODE:   r_cfg.mode            <= i_cfg_data[0];
                dfbs_pkg::REG_FLAG:   r_cfg.flag_byte       <= i_cfg_data;
                dfbs_pkg::REG_ESCAPE: r_cfg.escape_byte     <= i_cfg_data;
                dfbs_pkg::REG_MASK:   r_cfg.complement_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the beat and work out the next decode state
    always_comb begin
        n_esc_pend = r_esc_pend;
        n_in_frame = r_in_frame;
        n_has_data = r_has_data;
        o_push     = 1'b0;
        o_cmd      = '0;
        if (r_cfg.mode == dfbs_pkg::MODE_ENCODE) begin
            o_push                        = accept;
            o_cmd.parts[dfbs_pkg::PART_OPEN]  = i_start;
            o_cmd.parts[dfbs_pkg::PART_ESC]   = is_flag || is_esc;
            o_cmd.parts[dfbs_pkg::PART_DATA]  = 1'b1;
            o_cmd.parts[dfbs_pkg::PART_CLOSE] = i_end;
            o_cmd.data = (is_flag || is_esc) ? (i_byte ^ r_cfg.complement_mask) : i_byte;
        end else if (!r_in_frame) begin
            // hunt for the opening flag
            if (is_flag) begin
                n_in_frame = 1'b1;
                n_has_data = 1'b0;
                n_esc_pend = 1'b0;
            end
        end else if (is_flag) begin
            // a flag ends a frame that held data; a dangling escape is dropped
            n_esc_pend = 1'b0;
            if (r_has_data) begin
                o_push = accept;
                o_cmd.parts[dfbs_pkg::PART_DATA] = 1'b1;
                o_cmd.eof  = 1'b1;
                n_has_data = 1'b0;
            end
        end else if (r_esc_pend) begin
            n_esc_pend = 1'b0;
            n_has_data = 1'b1;
            o_push     = accept;
            o_cmd.parts[dfbs_pkg::PART_DATA] = 1'b1;
            o_cmd.data = i_byte ^ r_cfg.complement_mask;
        end else if (is_esc) begin
            n_esc_pend = 1'b1;
        end else begin
            n_has_data = 1'b1;
            o_push     = accept;
            o_cmd.parts[dfbs_pkg::PART_DATA] = 1'b1;
            o_cmd.data = i_byte;
        end
    end

    // Advance the decode state; a mode write clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pend <= 1'b0;
            r_in_frame <= 1'b0;
            r_has_data <= 1'b0;
        end else if (cfg_wr && i_cfg_index == dfbs_pkg::REG_MODE) begin
            r_esc_pend <= 1'b0;
            r_in_frame <= 1'b0;
            r_has_data <= 1'b0;
        end else if (accept) begin
            r_esc_pend <= n_esc_pend;
            r_in_frame <= n_in_frame;
            r_has_data <= n_has_data;
        end
    end

endmodule

@@ rtl/dfbs_queue.sv @@
// Short command queue between the front and the back part.
module dfbs_queue #(
    parameter int Depth = dfbs_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dfbs_pkg::t_cmd i_wdata,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output dfbs_pkg::t_cmd o_rdata
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    dfbs_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CntW'(Depth));
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Write the entry at the tail
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");

endmodule

@@ rtl/dfbs_back.sv @@
// Back part: expands one queued command into result beats, one beat per cycle unless stalled.
module dfbs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dfbs_pkg::t_cfg i_cfg,
    // queue side
    input  logic           i_q_valid,
    input  dfbs_pkg::t_cmd i_q_cmd,
    output logic           o_pop,
    // result beat
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_eof,
    output logic           o_last
);

    logic [dfbs_pkg::PART_N-1:0] r_rem;
    logic [7:0]                  r_data;
    logic                        r_eof;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_eof;
    logic       r_out_last;

    logic                        busy;
    logic                        adv;
    logic                        take;
    logic [dfbs_pkg::PART_N-1:0] rem_after;
    logic                        done;
    logic [7:0]                  emit_byte;

    assign busy      = (r_rem != '0);
    assign adv       = !r_out_valid || i_ready;
    assign take      = busy && adv;
    assign rem_after = r_rem & (r_rem - 1'b1);
    assign done      = (rem_after == '0);
    assign o_pop     = i_q_valid && (!busy || (take && done));

    // Pick the byte of the lowest remaining part
    always_comb begin
        if (r_rem[dfbs_pkg::PART_OPEN]) begin
            emit_byte = i_cfg.flag_byte;
        end else if (r_rem[dfbs_pkg::PART_ESC]) begin
            emit_byte = i_cfg.escape_byte;
        end else if (r_rem[dfbs_pkg::PART_DATA]) begin
            emit_byte = r_eof ? 8'h00 : r_data;
        end else begin
            emit_byte = i_cfg.flag_byte;
        end
    end

    // Load the next command or drop the part just sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (o_pop) begin
            r_rem <= i_q_cmd.parts;
        end else if (take) begin
            r_rem <= rem_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_cmd.data;
            r_eof  <= i_q_cmd.eof;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_byte <= emit_byte;
            r_out_eof  <= r_eof;
            r_out_last <= done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_eof   = r_out_eof;
    assign o_last  = r_out_last;

    // A frame boundary is a single beat with a zero byte
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_eof |-> r_out_last && r_out_byte == 8'h00)
        else $error("frame boundary beat malformed");

    // A frame boundary command carries only the data part
    a_eof_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && r_eof |-> r_rem == (dfbs_pkg::PART_N'(1) << dfbs_pkg::PART_DATA))
        else $error("frame boundary command with other parts");

    // Output register empty after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result beat valid after reset");

    // A new command is loaded only when the current one finishes
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && busy |-> take && done)
        else $error("command loaded over unfinished one");

endmodule

@@ rtl/diag_frame_byte_stuffing.sv @@
// Path: an accepted beat goes through the queue, the back's command register and its
// output register. Throughput: one input beat per cycle while each gives at most one
// result and the sink keeps up; the back emits one result beat per cycle unless held off,
// and an encoded byte gives one to four beats; a decoded byte with no result is not queued.
// Reset (synchronous, active low) restores the register defaults and empties queue and output.
module diag_frame_byte_stuffing #(
    parameter int QueueDepth = dfbs_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] frame_start
    input  logic       s_axis_tlast,   // frame_end
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] end_of_frame
    output logic       m_axis_tlast    // last
);

    dfbs_pkg::t_cfg cfg;
    dfbs_pkg::t_cmd push_cmd;
    dfbs_pkg::t_cmd q_cmd;
    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;

    dfbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_start     (s_axis_tuser),
        .i_end       (s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_cfg       (cfg)
    );

    dfbs_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_rdata (q_cmd)
    );

    dfbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_eof     (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

@@ tb/sv/dfbs_stream_checker.sv @@
`timescale 1ns / 100ps
// Stream checker for the byte-stuffing codec: tracks register writes, predicts line beats, compares.
module dfbs_stream_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input stream
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_start,
    input  logic       i_in_end,
    // output stream
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_eof,
    input  logic       i_out_last,
    // results
    output int         o_errors,
    output int         o_pending
);

    typedef struct {
        logic [7:0] data;
        logic       eof;
        logic       last;
    } t_line_beat;

    // Shadow registers and decoder state
    logic       cfg_mode   = dfbs_pkg::MODE_ENCODE;
    logic [7:0] cfg_flag   = dfbs_pkg::FLAG_RESET;
    logic [7:0] cfg_escape = dfbs_pkg::ESCAPE_RESET;
    logic [7:0] cfg_mask   = dfbs_pkg::MASK_RESET;
    logic       esc_seen   = 1'b0;
    logic       in_frame   = 1'b0;
    logic       has_data   = 1'b0;

    t_line_beat due_beats[$];
    int         n_errors = 0;

    assign o_errors = n_errors;

    // Print one line per mismatch and count it
    task automatic report_error(input string msg);
        n_errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    function automatic t_line_beat mk_beat(input logic [7:0] data, input logic eof);
        t_line_beat r;
        r.data = data;
        r.eof  = eof;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        case (idx)
            dfbs_pkg::REG_MODE: begin
                cfg_mode = val[0];
                esc_seen = 1'b0;
                in_frame = 1'b0;
                has_data = 1'b0;
            end
            dfbs_pkg::REG_FLAG:   cfg_flag   = val;
            dfbs_pkg::REG_ESCAPE: cfg_escape = val;
            dfbs_pkg::REG_MASK:   cfg_mask   = val;
            default: ;
        endcase
    endtask

    // Stuff or unstuff one byte and queue the line beats it should give
    task automatic code_byte(input logic [7:0] b, input logic start, input logic fin);
        t_line_beat res[$];
        if (cfg_mode == dfbs_pkg::MODE_ENCODE) begin
            if (start) begin
                res.push_back(mk_beat(cfg_flag, 1'b0));
            end
            if (b == cfg_flag || b == cfg_escape) begin
                res.push_back(mk_beat(cfg_escape, 1'b0));
                res.push_back(mk_beat(b ^ cfg_mask, 1'b0));
            end else begin
                res.push_back(mk_beat(b, 1'b0));
            end
            if (fin) begin
                res.push_back(mk_beat(cfg_flag, 1'b0));
            end
        end else if (!in_frame) begin
            // hunting: only a flag opens a frame
            if (b == cfg_flag) begin
                in_frame = 1'b1;
                has_data = 1'b0;
                esc_seen = 1'b0;
            end
        end else if (b == cfg_flag) begin
            // drop a dangling escape; close the frame only if it carried data
            esc_seen = 1'b0;
            if (has_data) begin
                res.push_back(mk_beat(8'h00, 1'b1));
                has_data = 1'b0;
            end
        end else if (esc_seen) begin
            esc_seen = 1'b0;
            has_data = 1'b1;
            res.push_back(mk_beat(b ^ cfg_mask, 1'b0));
        end else if (b == cfg_escape) begin
            esc_seen = 1'b1;
        end else begin
            has_data = 1'b1;
            res.push_back(mk_beat(b, 1'b0));
        end
        if (res.size() > 0) begin
            res[res.size() - 1].last = 1'b1;
        end
        foreach (res[k]) begin
            due_beats.push_back(res[k]);
        end
    endtask

    // Watch all three channels at each edge
    always @(posedge i_clk) begin : watch
        t_line_beat want;
        if (!i_rst_n) begin
            cfg_mode   = dfbs_pkg::MODE_ENCODE;
            cfg_flag   = dfbs_pkg::FLAG_RESET;
            cfg_escape = dfbs_pkg::ESCAPE_RESET;
            cfg_mask   = dfbs_pkg::MASK_RESET;
            esc_seen   = 1'b0;
            in_frame   = 1'b0;
            has_data   = 1'b0;
            due_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                code_byte(i_in_byte, i_in_start, i_in_end);
            end
            if (i_out_valid && i_out_ready) begin
                if (due_beats.size() == 0) begin
                    report_error($sformatf("unexpected beat: data %02h eof %0b last %0b",
                                           i_out_byte, i_out_eof, i_out_last));
                end else begin
                    want = due_beats.pop_front();
                    if (i_out_byte !== want.data || i_out_eof !== want.eof ||
                        i_out_last !== want.last) begin
                        report_error($sformatf(
                            "beat mismatch: got %02h/%0b/%0b, expected %02h/%0b/%0b",
                            i_out_byte, i_out_eof, i_out_last,
                            want.data, want.eof, want.last));
                    end
                end
            end
        end
        o_pending <= due_beats.size();
    end

endmodule

@@ tb/sv/diag_frame_byte_stuffing_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the byte-stuffing codec: clock, reset, stimulus, pacing and verdict.
module diag_frame_byte_stuffing_tb;

    typedef struct {
        logic [7:0] b;
        logic       start;
        logic       fin;
    } t_in_item;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_index = 8'h00;
    logic [7:0] cfg_data  = 8'h00;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       s_tlast   = 1'b0;
    logic       m_tready  = 1'b0;

    logic       cfg_ready;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    int errors;
    int pending;

    // Pacing controls: steady is shared by the source and the sink, hold_req is for the sink only
    bit steady    = 1'b0;
    int hold_req  = 0;

    // Current register settings, used to shape frames
    logic [7:0] cur_flag   = dfbs_pkg::FLAG_RESET;
    logic [7:0] cur_escape = dfbs_pkg::ESCAPE_RESET;
    logic [7:0] cur_mask   = dfbs_pkg::MASK_RESET;

    t_in_item plan[$];

    always #6 i_clk = ~i_clk;

    diag_frame_byte_stuffing dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // [7:0] in_byte
        .s_axis_tuser  (s_tuser),   // [0] frame_start
        .s_axis_tlast  (s_tlast),   // frame_end
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // [7:0] out_byte
        .m_axis_tuser  (m_tuser),   // [0] end_of_frame
        .m_axis_tlast  (m_tlast)    // last
    );

    dfbs_stream_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_byte   (s_tdata),
        .i_in_start  (s_tuser),
        .i_in_end    (s_tlast),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_byte  (m_tdata),
        .i_out_eof   (m_tuser),
        .i_out_last  (m_tlast),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in_item mk_item(input logic [7:0] b, input logic start,
                                         input logic fin);
        t_in_item it;
        it.b     = b;
        it.start = start;
        it.fin   = fin;
        return it;
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Favour the flag and escape values so stuffing is hit often
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5) return cur_flag;
        if (r < 10) return cur_escape;
        if (r == 10) return 8'h00;
        if (r == 11) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one beat, after a random gap, and hold it until taken
    task automatic send_item(input t_in_item it);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.b;
        s_tuser  <= it.start;
        s_tlast  <= it.fin;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send(input logic [7:0] b, input logic start, input logic fin);
        send_item(mk_item(b, start, fin));
    endtask

    // Stop offering and wait until every predicted beat is back and the pipe is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_phase(input logic md, input logic [7:0] flag, input logic [7:0] esc,
                             input logic [7:0] mask);
        cfg_write(dfbs_pkg::REG_FLAG, flag);
        cfg_write(dfbs_pkg::REG_ESCAPE, esc);
        cfg_write(dfbs_pkg::REG_MASK, mask);
        cfg_write(dfbs_pkg::REG_MODE, {7'b0, md});
        cur_flag   = flag;
        cur_escape = esc;
        cur_mask   = mask;
    endtask

    // Line traffic: mostly proper frames, with stray bytes, repeats and dangling escapes
    task automatic make_decode_frame();
        int         n;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0) plan.push_back(mk_item(pick_byte(), rbit(), rbit()));
        plan.push_back(mk_item(cur_flag, rbit(), rbit()));
        if ($urandom_range(0, 4) == 0) plan.push_back(mk_item(cur_flag, rbit(), rbit()));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 5);
        repeat (n) begin
            b = pick_byte();
            if ($urandom_range(0, 11) == 0) begin
                plan.push_back(mk_item(pick_byte(), rbit(), rbit()));
            end else if (b == cur_flag || b == cur_escape) begin
                plan.push_back(mk_item(cur_escape, rbit(), rbit()));
                plan.push_back(mk_item(b ^ cur_mask, rbit(), rbit()));
            end else begin
                plan.push_back(mk_item(b, rbit(), rbit()));
            end
        end
        if ($urandom_range(0, 3) != 0) plan.push_back(mk_item(cur_flag, rbit(), rbit()));
    endtask

    // Payload frames: start on the first byte, end on the last, some stray markers
    task automatic make_encode_frame();
        int   n;
        logic s;
        logic e;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
            s = (k == 0);
            e = (k == n - 1);
            if ($urandom_range(0, 9) == 0) begin
                s = rbit();
                e = rbit();
            end
            plan.push_back(mk_item(pick_byte(), s, e));
        end
    endtask

    // Sink pacing: random stalls, or a long hold-off when one is requested
    initial begin : sink_pacing
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = steady ? 0 : gap_len();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [7:0] f;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Encode at reset values: plain, extremes, flag and escape, both markers at once
        send(8'h00, 1'b1, 1'b0);
        send(8'hFF, 1'b0, 1'b0);
        send(dfbs_pkg::FLAG_RESET, 1'b0, 1'b0);
        send(dfbs_pkg::ESCAPE_RESET, 1'b0, 1'b1);
        send(8'h55, 1'b1, 1'b1);
        send(dfbs_pkg::FLAG_RESET, 1'b1, 1'b1);
        send(8'hAA, 1'b0, 1'b1);
        drain();

        // Encode with flag equal to escape: the byte is escaped
        set_phase(dfbs_pkg::MODE_ENCODE, 8'h00, 8'h00, 8'hFF);
        send(8'h00, 1'b1, 1'b1);
        send(8'hFF, 1'b0, 1'b0);
        drain();

        // Decode; writes to unknown indexes must change nothing
        set_phase(dfbs_pkg::MODE_DECODE, dfbs_pkg::FLAG_RESET, dfbs_pkg::ESCAPE_RESET,
                  dfbs_pkg::MASK_RESET);
        cfg_write(8'h04, 8'hA5);
        cfg_write(8'hFF, 8'h5A);
        send(8'h11, 1'b0, 1'b0);                    // hunting: dropped
        send(dfbs_pkg::ESCAPE_RESET, 1'b0, 1'b0);   // hunting: dropped
        send(dfbs_pkg::FLAG_RESET, 1'b0, 1'b0);     // opens the frame
        send(dfbs_pkg::FLAG_RESET, 1'b0, 1'b0);     // repeated flag
        send(8'h41, 1'b0, 1'b0);
        send(dfbs_pkg::ESCAPE_RESET, 1'b0, 1'b0);
        send(8'h5E, 1'b0, 1'b0);                    // unescapes to the flag value
        send(dfbs_pkg::ESCAPE_RESET, 1'b0, 1'b0);
        send(dfbs_pkg::FLAG_RESET, 1'b0, 1'b0);     // dangling escape dropped, frame ends
        send(dfbs_pkg::FLAG_RESET, 1'b0, 1'b0);
        send(dfbs_pkg::ESCAPE_RESET, 1'b0, 1'b0);
        send(dfbs_pkg::FLAG_RESET, 1'b0, 1'b0);     // escape then flag on an empty frame
        send(8'h00, 1'b1, 1'b1);                    // framing markers ignored
        send(dfbs_pkg::FLAG_RESET, 1'b0, 1'b0);
        drain();

        // Random phases over a spread of settings
        for (int ph = 0; ph < 8; ph++) begin
            f = 8'($urandom_range(0, 255));
            case (ph)
                0: set_phase(dfbs_pkg::MODE_ENCODE, dfbs_pkg::FLAG_RESET,
                             dfbs_pkg::ESCAPE_RESET, dfbs_pkg::MASK_RESET);
                1: set_phase(dfbs_pkg::MODE_DECODE, dfbs_pkg::FLAG_RESET,
                             dfbs_pkg::ESCAPE_RESET, dfbs_pkg::MASK_RESET);
                2: set_phase(dfbs_pkg::MODE_ENCODE, 8'h00, 8'hFF, 8'hFF);
                3: set_phase(dfbs_pkg::MODE_DECODE, 8'hFF, 8'h00, 8'h00);
                4: set_phase(dfbs_pkg::MODE_DECODE, f, f, 8'($urandom_range(0, 255)));
                5: set_phase(dfbs_pkg::MODE_ENCODE, f, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                6: set_phase(dfbs_pkg::MODE_DECODE, f, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                default: set_phase(dfbs_pkg::MODE_ENCODE, f, f, 8'($urandom_range(0, 255)));
            endcase
            plan.delete();
            while (plan.size() < 36) begin
                if ((ph % 2) == 1 || ph == 4) make_decode_frame();
                else make_encode_frame();
            end
            steady = (ph == 1 || ph == 2 || ph == 5);
            // hold the sink off while the source keeps offering, so the input stalls
            if (ph == 1 || ph == 2) hold_req = 150;
            foreach (plan[k]) send_item(plan[k]);
            drain();
        end
        steady = 1'b0;

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dfbs_pkg.sv
rtl/dfbs_front.sv
rtl/dfbs_queue.sv
rtl/dfbs_back.sv
rtl/diag_frame_byte_stuffing.sv
tb/sv/dfbs_stream_checker.sv
tb/sv/diag_frame_byte_stuffing_tb.sv
